### rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;
    localparam int WORD_BITS = 32;

    localparam logic [2:0] KIND_ADD = 3'd0;
    localparam logic [2:0] KIND_SUB = 3'd1;
    localparam logic [2:0] KIND_MUL = 3'd2;
    localparam logic [2:0] KIND_DIV = 3'd3;
    localparam logic [2:0] KIND_NRM = 3'd4;
    localparam logic [2:0] KIND_EQU = 3'd5;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] left_num;
        logic signed [31:0] left_den;
        logic signed [31:0] right_num;
        logic signed [31:0] right_den;
    } t_req;

    typedef struct packed {
        logic signed [31:0] out_num;
        logic signed [31:0] out_den;
        logic               is_equal;
    } t_res;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // capture request
        logic mul1;     // first products
        logic mul2;     // second products, raw result
        logic setup;    // magnitudes and signs
        logic gcd_step; // one binary gcd step
        logic div_init; // start division by gcd
        logic div_step; // one restoring division bit
        logic finish;   // form result
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic zero;     // raw result is zero over anything or anything over zero
        logic gcd_done;
        logic div_last;
    } t_sts;
endpackage

### rtl/rational_arith_unit_top.sv
// ----------------------------------------------------------------------------
// rational_arith_unit_top
// Rational add, subtract, multiply, divide, normalize and equality.
// ----------------------------------------------------------------------------
// usage:
//   a request transfers when i_start is high and o_busy is low; i_req holds
//   the kind and the two fractions. one result per request appears on o_res,
//   flagged by o_valid for exactly one cycle; the receiver cannot stall.
// sequence:
//   products and setup, then the binary gcd loop (one step a cycle), then the
//   shared restoring division of both parts by the gcd, then the result is
//   formed and shown. zero numerator or denominator skips the loops.
// throughput:
//   one request at a time; o_busy falls the cycle the result is shown.
// reset:
//   i_rst_n synchronous active low returns the sequencer to idle and drops
//   o_valid; no request in flight survives.
// ----------------------------------------------------------------------------
module rational_arith_unit_top import rau_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    output logic o_busy,
    output logic o_valid,
    output t_res o_res
);
    t_cmd cmd;
    t_sts sts;

    rau_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start),
        .i_sts(sts), .o_cmd(cmd), .o_busy(o_busy), .o_valid(o_valid)
    );

    rau_datapath u_dp (
        .i_clk(i_clk), .i_req(i_req), .i_cmd(cmd), .o_sts(sts), .o_res(o_res)
    );
endmodule

### rtl/rau_datapath.sv
// ----------------------------------------------------------------------------
// rau_datapath
// Products, binary gcd and two shared-step restoring divisions by the gcd.
// ----------------------------------------------------------------------------
module rau_datapath import rau_pkg::*; (
    input  logic i_clk,
    input  t_req i_req,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output t_res o_res
);
    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(W + 1);

    logic [2:0]   r_kind;
    logic [W-1:0] r_ln, r_ld, r_rn, r_rd;
    logic [W-1:0] r_p0, r_p1, r_n, r_d;
    logic [W-1:0] r_ga, r_gb, r_g;
    logic [CW-1:0] r_sh, r_cnt;
    logic [W-1:0] r_mn, r_md, r_qn, r_qd, r_remn, r_remd;
    logic         r_neg, r_eq;
    t_res         r_res;

    logic [W-1:0] ma, mb, mc, md_;
    logic [W-1:0] n_qn, n_qd, n_remn, n_remd;
    logic [W:0]   tn, td;

    // operand selection for the two multipliers of each product cycle
    always_comb begin
        ma = r_ln; mb = r_rd; mc = r_rn; md_ = r_ld;
        if (i_cmd.mul2) begin
            ma = r_ld; mb = r_rd; mc = r_ld; md_ = r_rn;
        end
        if (i_cmd.mul1 && r_kind == KIND_MUL) mb = r_rn;
    end

    // one restoring division bit for numerator and denominator
    always_comb begin
        tn = {r_remn, r_qn[W-1]};
        td = {r_remd, r_qd[W-1]};
        n_qn = {r_qn[W-2:0], 1'b0};
        n_qd = {r_qd[W-2:0], 1'b0};
        n_remn = tn[W-1:0];
        n_remd = td[W-1:0];
        if (tn >= {1'b0, r_g}) begin
            n_remn = W'(tn - {1'b0, r_g});
            n_qn[0] = 1'b1;
        end
        if (td >= {1'b0, r_g}) begin
            n_remd = W'(td - {1'b0, r_g});
            n_qd[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_req.kind;
            r_ln <= i_req.left_num[W-1:0];
            r_ld <= i_req.left_den[W-1:0];
            r_rn <= i_req.right_num[W-1:0];
            r_rd <= i_req.right_den[W-1:0];
            r_eq <= (i_req.kind == KIND_EQU) &&
                    (i_req.left_num[W-1:0] == i_req.right_num[W-1:0]) &&
                    (i_req.left_den[W-1:0] == i_req.right_den[W-1:0]);
        end
        if (i_cmd.mul1) begin
            r_p0 <= W'(ma * mb);
            r_p1 <= W'(mc * md_);
        end
        // raw numerator and denominator
        if (i_cmd.mul2) begin
            case (r_kind)
                KIND_ADD: begin r_n <= W'(r_p0 + r_p1); r_d <= W'(ma * mb); end
                KIND_SUB: begin r_n <= W'(r_p0 - r_p1); r_d <= W'(ma * mb); end
                KIND_MUL: begin r_n <= r_p0;            r_d <= W'(ma * mb); end
                KIND_DIV: begin r_n <= r_p0;            r_d <= W'(mc * md_); end
                KIND_NRM: begin r_n <= r_ln;            r_d <= r_ld; end
                default:  begin r_n <= '0;              r_d <= W'(1); end
            endcase
        end
        if (i_cmd.setup) begin
            r_mn <= r_n[W-1] ? W'(-r_n) : r_n;
            r_md <= r_d[W-1] ? W'(-r_d) : r_d;
            r_ga <= r_n[W-1] ? W'(-r_n) : r_n;
            r_gb <= r_d[W-1] ? W'(-r_d) : r_d;
            r_neg <= r_n[W-1] ^ r_d[W-1];
            r_sh <= '0;
        end
        // binary gcd step
        if (i_cmd.gcd_step) begin
            if (!r_ga[0] && !r_gb[0]) begin
                r_ga <= r_ga >> 1; r_gb <= r_gb >> 1; r_sh <= CW'(r_sh + 1'b1);
            end else if (!r_ga[0]) begin
                r_ga <= r_ga >> 1;
            end else if (!r_gb[0]) begin
                r_gb <= r_gb >> 1;
            end else if (r_ga >= r_gb) begin
                r_ga <= (r_ga - r_gb) >> 1;
            end else begin
                r_gb <= (r_gb - r_ga) >> 1;
            end
        end
        if (i_cmd.div_init) begin
            r_g <= (r_ga | r_gb) << r_sh;
            r_qn <= r_mn; r_qd <= r_md;
            r_remn <= '0; r_remd <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_qn <= n_qn; r_qd <= n_qd;
            r_remn <= n_remn; r_remd <= n_remd;
            r_cnt <= CW'(r_cnt + 1'b1);
        end
        if (i_cmd.finish) begin
            if (r_n == '0 || r_d == '0) begin
                r_res.out_num <= '0;
                r_res.out_den <= 32'sd1;
            end else begin
                r_res.out_num <= 32'(signed'(r_neg ? W'(-r_qn) : r_qn));
                r_res.out_den <= 32'(signed'(r_qd));
            end
            r_res.is_equal <= r_eq;
        end
    end

    assign o_sts.zero     = (r_n == '0) || (r_d == '0);
    assign o_sts.gcd_done = (r_ga == '0) || (r_gb == '0);
    assign o_sts.div_last = (r_cnt == CW'(W - 1));
    assign o_res = r_res;
endmodule

### rtl/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: products, gcd loop, division loop, result strobe.
// ----------------------------------------------------------------------------
module rau_ctrl import rau_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy,
    output logic o_valid
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL1  = 3'd1;
    localparam logic [2:0] ST_MUL2  = 3'd2;
    localparam logic [2:0] ST_SETUP = 3'd3;
    localparam logic [2:0] ST_GCD   = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_valid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            ST_IDLE: if (i_start) begin
                o_cmd.load = 1'b1; n_state = ST_MUL1;
            end
            ST_MUL1: begin o_cmd.mul1 = 1'b1; n_state = ST_MUL2; end
            ST_MUL2: begin o_cmd.mul2 = 1'b1; n_state = ST_SETUP; end
            ST_SETUP: begin
                if (i_sts.zero) n_state = ST_FIN;
                else begin o_cmd.setup = 1'b1; n_state = ST_GCD; end
            end
            ST_GCD: begin
                if (i_sts.gcd_done) begin
                    o_cmd.div_init = 1'b1; n_state = ST_DIV;
                end else o_cmd.gcd_step = 1'b1;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = ST_FIN;
            end
            ST_FIN: begin o_cmd.finish = 1'b1; n_state = ST_IDLE; end
            default: n_state = ST_IDLE;
        endcase
    end

    // state register and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= o_cmd.finish;
        end
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = r_valid;
endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rational arithmetic unit: a directed table of
// corner requests followed by random requests; each result is compared with
// the table's want or a local model of the fraction arithmetic and reduction.
// ----------------------------------------------------------------------------
module tb_top;
    import rau_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    t_req i_req;
    logic o_busy;
    logic o_valid;
    t_res o_res;

    t_res exp_q[$];
    int   n_err;
    int   idle_pct;

    rational_arith_unit_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    // clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // run limit
    initial begin
        #50ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // report one mismatch
    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t mismatch %s got %h want %h", $realtime, what, got, want);
        n_err++;
    endtask

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? -v : v;
    endfunction

    // reduce a raw fraction to lowest terms, sign on the numerator
    function automatic t_res reduce_frac(input logic [31:0] n, input logic [31:0] d);
        t_res r;
        logic [31:0] a, b, t, qn, qd;
        r.is_equal = 1'b0;
        if (n == 0 || d == 0) begin
            r.out_num = 32'sd1 - 32'sd1;
            r.out_den = 32'sd1;
            return r;
        end
        a = mag32(n);
        b = mag32(d);
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        qn = mag32(n) / a;
        qd = mag32(d) / a;
        r.out_num = (n[31] != d[31]) ? -qn : qn;
        r.out_den = qd;
        return r;
    endfunction

    // expected result of one request
    function automatic t_res rational_result(input t_req q);
        logic [31:0] n, d;
        t_res r;
        n = 0;
        d = 1;
        case (q.kind)
            KIND_ADD: begin
                n = q.left_num * q.right_den + q.right_num * q.left_den;
                d = q.left_den * q.right_den;
            end
            KIND_SUB: begin
                n = q.left_num * q.right_den - q.right_num * q.left_den;
                d = q.left_den * q.right_den;
            end
            KIND_MUL: begin
                n = q.left_num * q.right_num;
                d = q.left_den * q.right_den;
            end
            KIND_DIV: begin
                n = q.left_num * q.right_den;
                d = q.left_den * q.right_num;
            end
            KIND_NRM: begin
                n = q.left_num;
                d = q.left_den;
            end
            default: ;
        endcase
        r = reduce_frac(n, d);
        if (q.kind == KIND_EQU)
            r.is_equal = (q.left_num == q.right_num) && (q.left_den == q.right_den);
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (exp_q.size() == 0) begin
                report("unexpected", o_res.out_num, 32'd0);
            end else begin
                if (o_res.out_num !== exp_q[0].out_num)
                    report("out_num", o_res.out_num, exp_q[0].out_num);
                if (o_res.out_den !== exp_q[0].out_den)
                    report("out_den", o_res.out_den, exp_q[0].out_den);
                if (o_res.is_equal !== exp_q[0].is_equal)
                    report("is_equal", 32'(o_res.is_equal), 32'(exp_q[0].is_equal));
                void'(exp_q.pop_front());
            end
        end
    end

    // one transfer, with optional idle cycles ahead of it; returns on the
    // rising edge after the block has gone idle again
    task automatic send(input t_req q, input bit typed, input t_res want);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_req   <= q;
        @(posedge i_clk);
        exp_q.push_back(typed ? want : rational_result(q));
        i_start <= 1'b0;
        @(negedge i_clk);
        while (o_busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(15);
            2: return -$urandom_range(15);
            3: return 32'h8000_0000 ^ $urandom_range(3);
            4: return $urandom_range(4096) - 2048;
            default: return ($urandom_range(200) - 100) * ($urandom_range(20) + 1);
        endcase
    endfunction

    typedef struct {
        t_req q;
        bit   typed;
        t_res want;
    } t_row;

    t_row rows[$];

    function automatic t_row mk(input logic [2:0] k, input logic [31:0] a, input logic [31:0] b,
                                input logic [31:0] c, input logic [31:0] e, input bit typed,
                                input logic [31:0] wn, input logic [31:0] wd, input logic we);
        t_row r;
        r.q = '{k, a, b, c, e};
        r.typed = typed;
        r.want = '{wn, wd, we};
        return r;
    endfunction

    initial begin
        t_req q;
        int   ph;
        n_err    = 0;
        idle_pct = 0;
        i_rst_n  = 1'b0;
        i_start  = 1'b0;
        i_req    = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        rows.push_back(mk(KIND_ADD, 1, 2, 1, 3, 1, 5, 6, 0));
        rows.push_back(mk(KIND_SUB, 1, 2, 1, 2, 1, 0, 1, 0));
        rows.push_back(mk(KIND_MUL, 2, 3, 3, 4, 1, 1, 2, 0));
        rows.push_back(mk(KIND_DIV, 1, 2, 0, 1, 1, 0, 1, 0));
        rows.push_back(mk(KIND_DIV, 3, 4, -3, 2, 1, -1, 2, 0));
        rows.push_back(mk(KIND_NRM, 4, -8, 0, 0, 1, -1, 2, 0));
        rows.push_back(mk(KIND_NRM, 5, 0, 0, 0, 1, 0, 1, 0));
        rows.push_back(mk(KIND_NRM, 0, 7, 0, 0, 1, 0, 1, 0));
        rows.push_back(mk(KIND_EQU, 3, 4, 3, 4, 1, 0, 1, 1));
        rows.push_back(mk(KIND_EQU, 3, 4, 3, 5, 1, 0, 1, 0));
        rows.push_back(mk(KIND_EQU, 3, 4, 2, 4, 1, 0, 1, 0));
        rows.push_back(mk(3'd6, 1, 2, 3, 4, 1, 0, 1, 0));
        rows.push_back(mk(3'd7, -1, -1, -1, -1, 1, 0, 1, 0));
        rows.push_back(mk(KIND_NRM, 32'h8000_0000, 1, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(KIND_NRM, 1, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(KIND_NRM, 32'h8000_0000, 32'h8000_0000, 0, 0, 1, 1, 1, 0));
        rows.push_back(mk(KIND_NRM, 32'h7fff_ffff, -1, 0, 0, 1, 32'h8000_0001, 1, 0));
        rows.push_back(mk(KIND_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                          32'h7fff_ffff, 0, 0, 0, 0));
        rows.push_back(mk(KIND_MUL, 32'h8000_0000, -1, 32'h7fff_ffff, 3, 0, 0, 0, 0));
        rows.push_back(mk(KIND_SUB, -1, -1, -1, -1, 1, 0, 1, 0));
        rows.push_back(mk(KIND_DIV, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                          32'hffff_ffff, 0, 0, 0, 0));
        rows.push_back(mk(KIND_EQU, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                          32'h7fff_ffff, 1, 0, 1, 1));
        foreach (rows[i]) send(rows[i].q, rows[i].typed, rows[i].want);

        // wait for the pipeline to drain before the random part
        while (exp_q.size() != 0) @(posedge i_clk);

        // random part in idle phases
        for (int i = 0; i < 1300; i++) begin
            ph = i / 325;
            idle_pct = (ph == 0) ? 0 : (ph == 1) ? 62 : (ph == 2) ? 37 : 0;
            q.kind = (i % 40 == 39) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
            q.left_num  = rnd_word();
            q.left_den  = rnd_word();
            q.right_num = rnd_word();
            q.right_den = rnd_word();
            if (q.kind == KIND_EQU && $urandom_range(1)) begin
                q.right_num = q.left_num;
                if ($urandom_range(3) != 0) q.right_den = q.left_den;
            end
            send(q, 1'b0, '0);
            if (i == 700)
                while (exp_q.size() != 0) @(posedge i_clk);
        end

        // drain
        while (exp_q.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        if (n_err == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
